// ----- src/srs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants
// Widths, default depth and the job record passed from the load side to the
// selection side.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_SCORES_DEFAULT = 1024;
    localparam int SCORE_W            = 32;
    localparam int FRAC_W             = 32;
    localparam int OUT_W              = 10;

    // job fields are sized for the largest supported vector length
    localparam int JOB_CW = 17;
    localparam int JOB_IW = 16;
    localparam int JOB_SW = SCORE_W + JOB_CW;

    typedef struct packed {
        logic [JOB_CW-1:0]         count;
        logic signed [SCORE_W-1:0] min_score;
        logic [JOB_IW-1:0]         max_position;
        logic signed [JOB_SW-1:0]  raw_sum;
        logic [FRAC_W-1:0]         frac;
        logic                      bank;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

// ----- src/score_roulette_and_argmax_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// score_roulette_and_argmax_select: argmax and roulette-wheel pick
// Loads a vector of signed Q16.16 scores; on the last score returns the first
// maximum index and a roulette pick over min-shifted weights.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   push / full      score, rand_fraction, last
//  result    pop / empty      max_index, pick_index
//
//  scores load at one per cycle while full is low, into one of two ram banks
//  per vector the selector fetches the job, forms total and threshold in the
//  prod/total/mhi/mlo/thr states, scans the bank (one ram read per cycle)
//  and loads the output register when it is free; the next vector loads in the other bank
//  full rises when the bank to be loaded is still owned by a pending vector
//  reset clears counters, stats and queue; the score ram is not cleared
// ----------------------------------------------------------------------------
module score_roulette_and_argmax_select
    import srs_pkg::*;
#(
    parameter int MAX_SCORES = MAX_SCORES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [SCORE_W-1:0] score,
    input  logic [FRAC_W-1:0]         rand_fraction,
    input  logic                      last,
    output logic                      empty,
    input  logic                      pop,
    output logic [OUT_W-1:0]          max_index,
    output logic [OUT_W-1:0]          pick_index
);

    localparam int IW = $clog2(MAX_SCORES);

    logic               ram_we;
    logic [IW:0]        ram_waddr;
    logic [SCORE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW:0]        ram_raddr;
    logic [SCORE_W-1:0] ram_rdata;
    logic               job_push;
    job_t               job_in;
    logic               q_pop;
    logic               q_empty;
    job_t               q_head;
    release_t           rel;

    srs_front #(
        .MAX_SCORES(MAX_SCORES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .score        (score),
        .rand_fraction(rand_fraction),
        .last         (last),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .job_push     (job_push),
        .job          (job_in),
        .rel          (rel)
    );

    srs_ram #(
        .WIDTH(SCORE_W),
        .DEPTH(2 ** (IW + 1))
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    srs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .push_job(job_in),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    srs_back #(
        .MAX_SCORES(MAX_SCORES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (q_head),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rel       (rel),
        .empty     (empty),
        .pop       (pop),
        .max_index (max_index),
        .pick_index(pick_index)
    );

endmodule

// ----- src/srs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_ram: generic dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/srs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_front: score loader
// Stores each score (up to MAX_SCORES) in the current bank, tracks count,
// minimum, first maximum and sum; the last score hands a job to the selector.
// ----------------------------------------------------------------------------
module srs_front
    import srs_pkg::*;
#(
    parameter int MAX_SCORES = MAX_SCORES_DEFAULT,
    localparam int IW = $clog2(MAX_SCORES),
    localparam int CW = $clog2(MAX_SCORES + 1),
    localparam int SW = SCORE_W + CW
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [SCORE_W-1:0] score,
    input  logic [FRAC_W-1:0]         rand_fraction,
    input  logic                      last,
    output logic                      ram_we,
    output logic [IW:0]               ram_waddr,
    output logic [SCORE_W-1:0]        ram_wdata,
    output logic                      job_push,
    output job_t                      job,
    input  release_t                  rel
);

    logic [CW-1:0]             count_reg, count_next, count_upd;
    logic signed [SCORE_W-1:0] min_reg, min_next, min_upd;
    logic signed [SCORE_W-1:0] max_reg, max_next, max_upd;
    logic [IW-1:0]             pos_reg, pos_next, pos_upd;
    logic signed [SW-1:0]      sum_reg, sum_next, sum_upd;
    logic                      bank_reg, bank_next;
    logic [1:0]                busy_reg, busy_next;
    logic                      accept;
    logic                      room;
    logic                      take_max;

    assign full   = busy_reg[bank_reg];
    assign accept = push && !full;
    assign room   = count_reg < CW'(MAX_SCORES);

    assign take_max  = (count_reg == '0) || (score > max_reg);
    assign count_upd = room ? count_reg + CW'(1) : count_reg;
    assign min_upd   = (room && (score < min_reg)) ? score : min_reg;
    assign max_upd   = (room && take_max) ? score : max_reg;
    assign pos_upd   = (room && take_max) ? count_reg[IW-1:0] : pos_reg;
    assign sum_upd   = room ? sum_reg + SW'(score) : sum_reg;

    assign ram_we    = accept && room;
    assign ram_waddr = {bank_reg, count_reg[IW-1:0]};
    assign ram_wdata = score;

    assign job_push         = accept && last;
    assign job.count        = JOB_CW'(count_upd);
    assign job.min_score    = min_upd;
    assign job.max_position = JOB_IW'(pos_upd);
    assign job.raw_sum      = JOB_SW'(sum_upd);
    assign job.frac         = rand_fraction;
    assign job.bank         = bank_reg;

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (last)
            begin
                // vector closed: restart stats in the other bank
                count_next          = '0;
                min_next            = {1'b0, {(SCORE_W-1){1'b1}}};
                max_next            = {1'b1, {(SCORE_W-1){1'b0}}};
                pos_next            = '0;
                sum_next            = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                count_next = count_upd;
                min_next   = min_upd;
                max_next   = max_upd;
                pos_next   = pos_upd;
                sum_next   = sum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= {1'b0, {(SCORE_W-1){1'b1}}};
            max_reg   <= {1'b1, {(SCORE_W-1){1'b0}}};
            pos_reg   <= '0;
            sum_reg   <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ----- src/srs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_queue: job queue
// Two-entry fifo of job records between the loader and the selector.
// ----------------------------------------------------------------------------
module srs_queue
    import srs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_pop;

    assign empty  = (fill_reg == 2'd0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- src/srs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_back: roulette and argmax selector
// Takes a job, forms the min-shifted total and the threshold, scans the
// stored bank for the first running sum above the threshold and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module srs_back
    import srs_pkg::*;
#(
    parameter int MAX_SCORES = MAX_SCORES_DEFAULT,
    localparam int IW = $clog2(MAX_SCORES),
    localparam int CW = $clog2(MAX_SCORES + 1),
    localparam int SW = SCORE_W + CW
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  job_t               q_job,
    output logic               q_pop,
    output logic               ram_re,
    output logic [IW:0]        ram_raddr,
    input  logic [SCORE_W-1:0] ram_rdata,
    output release_t           rel,
    output logic               empty,
    input  logic               pop,
    output logic [OUT_W-1:0]   max_index,
    output logic [OUT_W-1:0]   pick_index
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROD  = 3'd1;
    localparam logic [2:0] S_TOTAL = 3'd2;
    localparam logic [2:0] S_MHI   = 3'd3;
    localparam logic [2:0] S_MLO   = 3'd4;
    localparam logic [2:0] S_THR   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             n_reg, n_next;
    logic signed [SCORE_W-1:0] min_reg, min_next;
    logic [IW-1:0]             best_reg, best_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic [FRAC_W-1:0]         frac_reg, frac_next;
    logic                      bank_reg, bank_next;
    logic signed [SW:0]        prod_reg, prod_next;
    logic [SW-1:0]             total_reg, total_next;
    logic [SW-1:0]             mhi_reg, mhi_next;
    logic [2*FRAC_W-1:0]       mlo_reg, mlo_next;
    logic [SW-1:0]             thr_reg, thr_next;
    logic [SW-1:0]             cdf_reg, cdf_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [CW-1:0]             chk_idx_reg, chk_idx_next;
    logic                      rvalid_reg, rvalid_next;
    logic [IW-1:0]             pick_reg, pick_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_best_reg, out_best_next;
    logic [OUT_W-1:0]          out_pick_reg, out_pick_next;

    logic signed [SW:0]        prod_c;
    logic signed [SW:0]        diff_c;
    logic [SW-1:0]             mhi_c;
    logic [2*FRAC_W-1:0]       mlo_c;
    logic [SW:0]               thr_c;
    logic signed [SCORE_W:0]   wdiff_c;
    logic [SW-1:0]             cdf_add;
    logic                      hit;
    logic                      last_chk;
    logic                      slot_free;
    logic [OUT_W+IW-1:0]       best_ext;
    logic [OUT_W+IW-1:0]       pick_ext;

    assign prod_c   = $signed({1'b0, n_reg}) * min_reg;
    assign diff_c   = (SW+1)'(sum_reg) - prod_reg;
    assign mhi_c    = frac_reg * total_reg[SW-1:SCORE_W];
    assign mlo_c    = frac_reg * total_reg[SCORE_W-1:0];
    assign thr_c    = {1'b0, mhi_reg} + (SW+1)'(mlo_reg[2*FRAC_W-1:FRAC_W]);
    assign wdiff_c  = (SCORE_W+1)'($signed(ram_rdata)) - (SCORE_W+1)'(min_reg);
    assign cdf_add  = cdf_reg + SW'(wdiff_c[SCORE_W-1:0]);
    assign hit      = thr_reg < cdf_add;
    assign last_chk = (chk_idx_reg == n_reg - CW'(1));

    assign slot_free = !out_valid_reg || pop;
    assign best_ext  = {{OUT_W{1'b0}}, best_reg};
    assign pick_ext  = {{OUT_W{1'b0}}, pick_reg};

    assign ram_raddr  = {bank_reg, rd_idx_reg[IW-1:0]};
    assign empty      = !out_valid_reg;
    assign max_index  = out_best_reg;
    assign pick_index = out_pick_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        frac_next      = frac_reg;
        bank_next      = bank_reg;
        prod_next      = prod_reg;
        total_next     = total_reg;
        mhi_next       = mhi_reg;
        mlo_next       = mlo_reg;
        thr_next       = thr_reg;
        cdf_next       = cdf_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        rvalid_next    = 1'b0;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg && !pop;
        out_best_next  = out_best_reg;
        out_pick_next  = out_pick_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        rel.valid      = 1'b0;
        rel.bank       = bank_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    n_next     = q_job.count[CW-1:0];
                    min_next   = q_job.min_score;
                    best_next  = q_job.max_position[IW-1:0];
                    sum_next   = q_job.raw_sum[SW-1:0];
                    frac_next  = q_job.frac;
                    bank_next  = q_job.bank;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                prod_next  = prod_c;
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                total_next = diff_c[SW-1:0];
                state_next = S_MHI;
            end
            S_MHI:
            begin
                mhi_next   = mhi_c;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                mlo_next   = mlo_c;
                state_next = S_THR;
            end
            S_THR:
            begin
                thr_next     = thr_c[SW-1:0];
                cdf_next     = '0;
                rd_idx_next  = '0;
                chk_idx_next = '0;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_idx_reg < n_reg)
                begin
                    ram_re      = 1'b1;
                    rvalid_next = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    cdf_next     = cdf_add;
                    chk_idx_next = chk_idx_reg + CW'(1);
                    if (hit || last_chk)
                    begin
                        // no hit by the end falls back to the last index
                        pick_next   = chk_idx_reg[IW-1:0];
                        rvalid_next = 1'b0;
                        rel.valid   = 1'b1;
                        state_next  = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = best_ext[OUT_W-1:0];
                    out_pick_next  = pick_ext[OUT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        min_reg      <= min_next;
        best_reg     <= best_next;
        sum_reg      <= sum_next;
        frac_reg     <= frac_next;
        bank_reg     <= bank_next;
        prod_reg     <= prod_next;
        total_reg    <= total_next;
        mhi_reg      <= mhi_next;
        mlo_reg      <= mlo_next;
        thr_reg      <= thr_next;
        cdf_reg      <= cdf_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        pick_reg     <= pick_next;
        out_best_reg <= out_best_next;
        out_pick_reg <= out_pick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for score_roulette_and_argmax_select
// Streams vectors of Q16.16 scores through the push/full side and checks each
// result on the pop/empty side against a typed-in expectation or a built-in
// selection model (first argmax and roulette pick over min-shifted weights).
// A short table of hand-picked vectors runs first, then random vectors of
// mixed length and content, with bursty requests, random pop stalls, one long
// pop hold-off, one vector longer than the score store, and full drains.
// ----------------------------------------------------------------------------
module tb_top;
    import srs_pkg::*;

    localparam int VEC_DEPTH    = MAX_SCORES_DEFAULT;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_EVERY  = 30;

    typedef struct packed {
        logic [OUT_W-1:0] best;
        logic [OUT_W-1:0] pick;
    } selection_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [FRAC_W-1:0]  frac;
        logic               last;
        logic               known;
        logic [OUT_W-1:0]   best;
        logic [OUT_W-1:0]   pick;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [SCORE_W-1:0] score;
    logic [FRAC_W-1:0]         rand_fraction;
    logic                      last;
    logic                      empty;
    logic                      pop;
    logic [OUT_W-1:0]          max_index;
    logic [OUT_W-1:0]          pick_index;

    // typed-in expectation travelling with the request
    logic                      row_known;
    logic [OUT_W-1:0]          row_best;
    logic [OUT_W-1:0]          row_pick;

    logic signed [SCORE_W-1:0] vec_scores [VEC_DEPTH];
    int unsigned               vec_len;
    logic signed [SCORE_W-1:0] vec_min;
    logic signed [SCORE_W-1:0] vec_max;
    int unsigned               vec_max_pos;
    longint                    vec_sum;

    selection_t                picks_due [$];
    int                        errors;
    int                        burst_left;
    bit                        hold_off_req;

    stim_row_t directed_rows [19] = '{
        // single score
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 10'd0, 10'd0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd0, 10'd0},
        // all scores equal at the top of the range
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd0, 10'd2},
        // min then max, zero fraction
        '{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 10'd1, 10'd1},
        // max, min, max at both fraction extremes
        '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd0, 10'd2},
        // tied maximum
        '{32'h0005_0000, 32'h1234_5678, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h0009_0000, 32'h0000_0000, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'h0009_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'hFFFD_0000, 32'h8000_0000, 1'b1, 1'b0, 10'd0, 10'd0},
        // negative scores only
        '{32'hFFFF_FFFF, 32'h5555_5555, 1'b0, 1'b0, 10'd0, 10'd0},
        '{32'hFFFF_0000, 32'h4000_0000, 1'b1, 1'b0, 10'd0, 10'd0}
    };

    score_roulette_and_argmax_select #(
        .MAX_SCORES(VEC_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .score        (score),
        .rand_fraction(rand_fraction),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .max_index    (max_index),
        .pick_index   (pick_index)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic clear_vector();
        vec_len     = 0;
        vec_min     = 32'sh7FFF_FFFF;
        vec_max     = 32'sh8000_0000;
        vec_max_pos = 0;
        vec_sum     = 0;
    endtask

    // update the running vector and, on the last score, queue the selection
    task automatic take_score(input logic signed [SCORE_W-1:0] s, input logic [FRAC_W-1:0] f,
                              input logic is_last, input logic known,
                              input logic [OUT_W-1:0] k_best, input logic [OUT_W-1:0] k_pick);
        longint            signed_total;
        longint unsigned   total;
        longint unsigned   run;
        longint unsigned   thr;
        logic [95:0]       prod;
        int unsigned       pick;
        selection_t        sel;
        if (vec_len < VEC_DEPTH)
        begin
            vec_scores[vec_len] = s;
            if (vec_len == 0 || s > vec_max)
            begin
                vec_max     = s;
                vec_max_pos = vec_len;
            end
            if (s < vec_min)
                vec_min = s;
            vec_sum += longint'(s);
            vec_len++;
        end
        if (!is_last)
            return;
        signed_total = vec_sum - longint'(vec_len) * longint'(vec_min);
        total        = signed_total;
        prod         = 96'(f) * 96'(total);
        thr          = prod[95:32];
        pick         = (vec_len > 0) ? vec_len - 1 : 0;
        run          = 0;
        for (int i = 0; i < vec_len; i++)
        begin
            run += longint'(vec_scores[i]) - longint'(vec_min);
            if (thr < run)
            begin
                pick = i;
                break;
            end
        end
        sel.best = known ? k_best : vec_max_pos[OUT_W-1:0];
        sel.pick = known ? k_pick : pick[OUT_W-1:0];
        picks_due = {picks_due, sel};
        clear_vector();
    endtask

    task automatic report_field(input string field, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    task automatic check_selection(input logic [OUT_W-1:0] b, input logic [OUT_W-1:0] p);
        selection_t want;
        if (picks_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t unexpected result: best %0d pick %0d", $realtime, b, p);
            return;
        end
        want = picks_due.pop_front();
        if (b !== want.best)
            report_field("max_index", want.best, b);
        if (p !== want.pick)
            report_field("pick_index", want.pick, p);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_selection(max_index, pick_index);
            if (push && !full)
                take_score(score, rand_fraction, last, row_known, row_best, row_pick);
        end
    end

    // one request with bursty spacing
    task automatic offer(input logic [SCORE_W-1:0] s, input logic [FRAC_W-1:0] f,
                         input logic l, input logic known,
                         input logic [OUT_W-1:0] k_best, input logic [OUT_W-1:0] k_pick);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push          <= 1'b1;
        score         <= s;
        rand_fraction <= f;
        last          <= l;
        row_known     <= known;
        row_best      <= k_best;
        row_pick      <= k_pick;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (picks_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SCORE_W-1:0] draw_score(input int mode);
        logic [SCORE_W-1:0] s;
        case (mode)
            0: s = $urandom();
            1: s = (int'($urandom_range(0, 6)) - 3) * 65536 + int'($urandom_range(0, 1));
            default:
                case ($urandom_range(3))
                    0: s = 32'h8000_0000;
                    1: s = 32'h7FFF_FFFF;
                    2: s = 32'h0000_0000;
                    default: s = 32'hFFFF_FFFF;
                endcase
        endcase
        return s;
    endfunction

    // mode: 0 full range, 1 narrow with ties, 2 all equal, 3 extremes
    task automatic send_vector(input int len, input int mode);
        logic [SCORE_W-1:0] base;
        logic [SCORE_W-1:0] s;
        logic [FRAC_W-1:0]  f;
        int                 r;
        base = draw_score($urandom_range(1) ? 0 : 3);
        for (int i = 0; i < len; i++)
        begin
            s = (mode == 2) ? base : draw_score(mode);
            r = $urandom_range(9);
            f = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
            offer(s, f, i == len - 1, 1'b0, '0, '0);
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int mode_left;
        int stall_pct;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        pop       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 200);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                mode_left--;
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int n_random;
        int v;
        int len;
        int r;
        int mode;
        rst_n         = 1'b0;
        push          = 1'b0;
        score         = '0;
        rand_fraction = '0;
        last          = 1'b0;
        row_known     = 1'b0;
        row_best      = '0;
        row_pick      = '0;
        errors        = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        clear_vector();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].score, directed_rows[i].frac, directed_rows[i].last,
                  directed_rows[i].known, directed_rows[i].best, directed_rows[i].pick);
        drain();

        // long pop hold-off while short vectors keep coming
        hold_off_req = 1'b1;
        n_random = 0;
        v = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            if (v == 10)
                send_vector(VEC_DEPTH + 3, 0);
            r = $urandom_range(99);
            if (r < 60)
                len = $urandom_range(1, 8);
            else if (r < 85)
                len = $urandom_range(9, 32);
            else
                len = $urandom_range(33, 100);
            r = $urandom_range(99);
            mode = (r < 40) ? 0 : (r < 75) ? 1 : (r < 85) ? 2 : 3;
            send_vector(len, mode);
            n_random += len;
            v++;
            if (v % DRAIN_EVERY == 0)
                drain();
        end
        drain();
        repeat (40) @(posedge clk);

        if (errors == 0 && picks_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
